/* design/dasp_pkg.sv */
package dasp_pkg;

	// Command kinds carried in the low bits of the input tuser
	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_DIR   = 3'd1,
		OP_SPEED = 3'd2,
		OP_START = 3'd3,
		OP_STOP  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		DIR_FWD  = 2'd0,
		DIR_BWD  = 2'd1,
		DIR_REV  = 2'd2,
		DIR_KEEP = 2'd3
	} dir_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef enum logic {
		REG_STEP_ANGLE    = 1'b0,
		REG_DEFAULT_SPEED = 1'b1
	} reg_index_t;

	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned RPM_W   = 16;
	// angle * 10000 needs 30 bits, 6 * rpm needs 19 bits
	localparam int unsigned NUM_W   = 30;
	localparam int unsigned DEN_W   = 19;
	localparam int unsigned SCALE_W = 14;
	localparam logic [SCALE_W-1:0] ANGLE_SCALE = 14'd10000;

	localparam logic [ANGLE_W-1:0] STEP_ANGLE_RST    = 16'd180;
	localparam logic [RPM_W-1:0]   DEFAULT_SPEED_RST = 16'd60;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

/* design/dasp_div.sv */
module dasp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  dasp_pkg::div_req_t req,
	output dasp_pkg::div_rsp_t rsp
);

	localparam int unsigned NW  = dasp_pkg::NUM_W;
	localparam int unsigned DW  = dasp_pkg::DEN_W;
	localparam int unsigned CW  = $clog2(NW);
	localparam logic [CW-1:0] LAST = CW'(NW - 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quot_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;

	logic [DW:0]   shifted;
	logic [DW:0]   trial;
	logic          fits;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q, quot_q[NW-1]};
		trial   = shifted - {1'b0, den_q};
		fits    = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == LAST);
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.num;
			rem_q  <= '0;
			den_q  <= req.den;
		end else if (run_q) begin
			quot_q <= {quot_q[NW-2:0], fits};
			rem_q  <= fits ? trial[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q && $past(run_q))
		else $error("divider done without a preceding run");

endmodule

/* design/dual_axis_stepper_pulse_generator_unit.sv */
// Two-axis step/direction pulse generator.
// Commands arrive on the s_axis channel: tuser holds the opcode and the axis,
// tdata the direction mode and the requested speed. Every accepted word gives
// exactly one result word on m_axis with all six driver lines after the update.
// A tick word stands for one microsecond of motor time.
// Tick, direction, start and stop words are done in the cycle they are taken;
// the result is valid from the next cycle. A set-speed word is a multiply
// into the dividend, then a shared restoring divider that settles one
// quotient bit per cycle. When the requested period does not fit, the
// divider runs again for the default speed. The block takes no word while
// a set-speed word is in progress.
// The result sits in an output register; a new word is taken while it waits
// only if it is taken in the same cycle, so a stalled receiver holds the
// result and stalls the input.
// cfg writes set the step angle and default speed and are always accepted.
// Reset: step angle 180, default speed 60 rpm, both axes stopped, forward,
// step low, half-periods and countdowns at the maximum, no result pending.
module dual_axis_stepper_pulse_generator_unit #(
	parameter int unsigned PERIOD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // dir_mode[1:0], speed_rpm[17:2], zero pad
	input  logic [3:0]  s_axis_tuser,  // opcode[2:0], axis[3]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // x_enable, x_direction, x_step,
	                                   // y_enable, y_direction, y_step, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int unsigned PB = PERIOD_BITS;
	localparam int unsigned QW = dasp_pkg::NUM_W;
	localparam logic [PB-1:0] PERIOD_MAX = {PB{1'b1}};

	dasp_pkg::state_t state_q, state_d;

	logic [dasp_pkg::ANGLE_W-1:0] angle_q;
	logic [dasp_pkg::RPM_W-1:0]   dflt_q;

	logic          x_dir_q, x_run_q, x_lvl_q;
	logic          y_dir_q, y_run_q, y_lvl_q;
	logic [PB-1:0] x_half_q, x_cnt_q, y_half_q, y_cnt_q;

	logic                         m_valid_q;
	logic [5:0]                   m_lines_q;

	logic                         axis_q;
	logic                         use_dflt_q;
	logic [dasp_pkg::RPM_W-1:0]   rpm_q;
	logic [dasp_pkg::NUM_W-1:0]   num_q;
	logic [dasp_pkg::DEN_W-1:0]   den_q;
	logic [PB-1:0]                half_q;

	dasp_pkg::div_req_t div_req;
	dasp_pkg::div_rsp_t div_rsp;

	dasp_pkg::opcode_t            in_op;
	dasp_pkg::dir_mode_t          in_mode;
	logic                         in_axis;
	logic [dasp_pkg::RPM_W-1:0]   in_rpm;

	logic                         accept;
	logic                         slot_free;
	logic                         prep_max;
	logic                         overflow;
	logic [QW+PB-1:0]             quot_ext;
	logic [dasp_pkg::RPM_W-1:0]   rpm_sel;
	logic                         fin_go;

	function automatic logic next_dir(input logic cur, input dasp_pkg::dir_mode_t mode);
		logic res;
		case (mode)
			dasp_pkg::DIR_FWD: res = 1'b0;
			dasp_pkg::DIR_BWD: res = 1'b1;
			dasp_pkg::DIR_REV: res = ~cur;
			default:           res = cur;
		endcase
		return res;
	endfunction

	assign in_op   = dasp_pkg::opcode_t'(s_axis_tuser[2:0]);
	assign in_axis = s_axis_tuser[3];
	assign in_mode = dasp_pkg::dir_mode_t'(s_axis_tdata[1:0]);
	assign in_rpm  = s_axis_tdata[17:2];

	assign slot_free = !m_valid_q || m_axis_tready;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	assign rpm_sel  = use_dflt_q ? dflt_q : rpm_q;
	assign prep_max = use_dflt_q && (dflt_q == '0);
	assign overflow = |(div_rsp.quot >> PB);
	assign quot_ext = {{PB{1'b0}}, div_rsp.quot};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dasp_pkg::ST_IDLE: begin
				if (accept && in_op == dasp_pkg::OP_SPEED) state_d = dasp_pkg::ST_PREP;
			end
			dasp_pkg::ST_PREP: begin
				state_d = prep_max ? dasp_pkg::ST_FIN : dasp_pkg::ST_LOAD;
			end
			dasp_pkg::ST_LOAD: state_d = dasp_pkg::ST_DIV;
			dasp_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					if (overflow && !use_dflt_q) state_d = dasp_pkg::ST_PREP;
					else state_d = dasp_pkg::ST_FIN;
				end
			end
			dasp_pkg::ST_FIN: begin
				if (slot_free) state_d = dasp_pkg::ST_IDLE;
			end
			default: state_d = dasp_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = num_q;
		div_req.den   = den_q;
		fin_go        = 1'b0;
		case (state_q)
			dasp_pkg::ST_IDLE: s_axis_tready = slot_free;
			dasp_pkg::ST_LOAD: div_req.start = 1'b1;
			dasp_pkg::ST_FIN:  fin_go = slot_free;
			default: ;
		endcase
	end

	dasp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dasp_pkg::ST_IDLE;
			angle_q    <= dasp_pkg::STEP_ANGLE_RST;
			dflt_q     <= dasp_pkg::DEFAULT_SPEED_RST;
			x_dir_q    <= 1'b0;
			x_run_q    <= 1'b0;
			x_lvl_q    <= 1'b0;
			x_half_q   <= PERIOD_MAX;
			x_cnt_q    <= PERIOD_MAX;
			y_dir_q    <= 1'b0;
			y_run_q    <= 1'b0;
			y_lvl_q    <= 1'b0;
			y_half_q   <= PERIOD_MAX;
			y_cnt_q    <= PERIOD_MAX;
			m_valid_q  <= 1'b0;
			use_dflt_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (dasp_pkg::reg_index_t'(cfg_index))
					dasp_pkg::REG_STEP_ANGLE:    angle_q <= cfg_data;
					dasp_pkg::REG_DEFAULT_SPEED: dflt_q  <= cfg_data;
					default: ;
				endcase
			end
			// every word but set-speed answers at once
			if ((accept && in_op != dasp_pkg::OP_SPEED) || fin_go) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (accept) begin
				case (in_op)
					dasp_pkg::OP_TICK: begin
						if (x_run_q) begin
							if (x_cnt_q[PB-1:1] == '0) begin
								x_lvl_q <= ~x_lvl_q;
								x_cnt_q <= x_half_q;
							end else begin
								x_cnt_q <= x_cnt_q - 1'b1;
							end
						end
						if (y_run_q) begin
							if (y_cnt_q[PB-1:1] == '0) begin
								y_lvl_q <= ~y_lvl_q;
								y_cnt_q <= y_half_q;
							end else begin
								y_cnt_q <= y_cnt_q - 1'b1;
							end
						end
					end
					dasp_pkg::OP_DIR: begin
						case (in_mode)
							dasp_pkg::DIR_FWD: begin
								if (in_axis) y_dir_q <= 1'b0; else x_dir_q <= 1'b0;
							end
							dasp_pkg::DIR_BWD: begin
								if (in_axis) y_dir_q <= 1'b1; else x_dir_q <= 1'b1;
							end
							dasp_pkg::DIR_REV: begin
								if (in_axis) y_dir_q <= ~y_dir_q; else x_dir_q <= ~x_dir_q;
							end
							default: ;
						endcase
					end
					dasp_pkg::OP_SPEED: use_dflt_q <= (in_rpm == '0);
					dasp_pkg::OP_START: begin
						if (in_axis) y_run_q <= 1'b1; else x_run_q <= 1'b1;
					end
					dasp_pkg::OP_STOP: begin
						if (in_axis) y_run_q <= 1'b0; else x_run_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == dasp_pkg::ST_DIV && div_rsp.done && overflow) use_dflt_q <= 1'b1;
			if (fin_go) begin
				if (axis_q) begin
					y_half_q <= half_q;
					y_cnt_q  <= half_q;
				end else begin
					x_half_q <= half_q;
					x_cnt_q  <= half_q;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			axis_q <= in_axis;
			rpm_q  <= in_rpm;
		end
		if (state_q == dasp_pkg::ST_PREP) begin
			num_q  <= QW'(angle_q) * QW'(dasp_pkg::ANGLE_SCALE);
			den_q  <= ({3'b000, rpm_sel} << 2) + ({3'b000, rpm_sel} << 1);
			if (prep_max) half_q <= PERIOD_MAX;
		end
		if (state_q == dasp_pkg::ST_DIV && div_rsp.done) begin
			half_q <= (overflow && use_dflt_q) ? PERIOD_MAX : quot_ext[PB-1:0];
		end
	end

	// snapshot the lines after the update into the output register
	always_ff @(posedge clk) begin
		if (accept && in_op != dasp_pkg::OP_SPEED) begin
			m_lines_q[0] <= (in_op == dasp_pkg::OP_START && !in_axis) ? 1'b1 :
			                (in_op == dasp_pkg::OP_STOP && !in_axis) ? 1'b0 : x_run_q;
			m_lines_q[1] <= (in_op == dasp_pkg::OP_DIR && !in_axis) ?
			                next_dir(x_dir_q, in_mode) : x_dir_q;
			m_lines_q[2] <= (in_op == dasp_pkg::OP_TICK && x_run_q &&
			                 x_cnt_q[PB-1:1] == '0) ? ~x_lvl_q : x_lvl_q;
			m_lines_q[3] <= (in_op == dasp_pkg::OP_START && in_axis) ? 1'b1 :
			                (in_op == dasp_pkg::OP_STOP && in_axis) ? 1'b0 : y_run_q;
			m_lines_q[4] <= (in_op == dasp_pkg::OP_DIR && in_axis) ?
			                next_dir(y_dir_q, in_mode) : y_dir_q;
			m_lines_q[5] <= (in_op == dasp_pkg::OP_TICK && y_run_q &&
			                 y_cnt_q[PB-1:1] == '0) ? ~y_lvl_q : y_lvl_q;
		end else if (fin_go) begin
			m_lines_q <= {y_lvl_q, y_dir_q, y_run_q, x_lvl_q, x_dir_q, x_run_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_lines_q};

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == dasp_pkg::ST_DIV)
		else $error("divider result outside the divide state");

	a_load_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dasp_pkg::ST_LOAD |=> state_q == dasp_pkg::ST_DIV)
		else $error("divider start not followed by wait");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> m_valid_q && state_q == dasp_pkg::ST_IDLE)
		else $error("set-speed result not posted");

endmodule
